@@ rtl/ldf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_pkg - length-prefixed frame deframer package
// Types and constants shared by the deframer, its channels and its checker.
// ----------------------------------------------------------------------------
package ldf_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned LEN_BYTES  = 4;
	localparam logic [LEN_W-1:0] MAX_FRAME_RST = 32'd1048576;

	// Deframer phase: four length bytes, type byte, payload, dead after error.
	typedef enum logic [2:0] {
		PH_LEN0    = 3'd0,
		PH_LEN1    = 3'd1,
		PH_LEN2    = 3'd2,
		PH_LEN3    = 3'd3,
		PH_TYPE    = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_DEAD    = 3'd6
	} phase_t;

	// Result kind codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_TYPE    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

endpackage

@@ rtl/ldf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_if - deframer channel interfaces
// Valid/ready channels for received bytes, frame results and configuration.
// ----------------------------------------------------------------------------
interface ldf_byte_if import ldf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldf_frame_if import ldf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] value;
	logic              last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

interface ldf_cfg_if import ldf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/length_prefixed_frame_deframer.sv @@
`timescale 1ns / 1ps
// Timing: a result beat appears on frame in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; rx stays ready while the result register is empty
//   or is being emptied in the same cycle, so a full stream never bubbles.
// Reset (arst_n low, asynchronous): phase back to the first length byte, result register
//   empty, max_frame_size back to 1048576. Reset is the only way out of the dead phase.
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer - 32-bit big-endian length-prefixed deframer
// Gathers a 4-byte length, checks it against zero and max_frame_size, then passes the
// type byte and the payload bytes on with a last flag on the final one.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer import ldf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ldf_byte_if.sink    rx,
	ldf_frame_if.source frame,
	ldf_cfg_if.sink     cfg
);

	// --- state ---------------------------------------------------------------
	phase_t                      phase_q, phase_d;
	// only the first three prefix bytes need holding; the fourth arrives live
	logic [LEN_W-BYTE_W-1:0]     len_acc_q, len_acc_d;
	logic [LEN_W-1:0]            remain_q, remain_d;
	logic [LEN_W-1:0]            max_frame_q;

	// --- result register -----------------------------------------------------
	logic                        res_valid_q, res_valid_d;
	kind_t                       res_kind_q, res_kind_d;
	logic [BYTE_W-1:0]           res_value_q, res_value_d;
	logic                        res_last_q, res_last_d;

	logic                        take;      // byte beat accepted this cycle
	logic                        res_free;  // result register may be loaded
	logic [LEN_W-1:0]            length;    // complete prefix, fourth byte live
	logic                        len_bad;
	logic                        fin;

	// The register empties when its beat is taken, so a new byte can land
	// in the same cycle as the old result leaves.
	assign res_free  = !res_valid_q || frame.ready;
	assign rx.ready  = res_free;
	assign take      = rx.valid && res_free;
	assign cfg.ready = 1'b1;

	assign length  = {len_acc_q, rx.rx_byte};
	assign len_bad = (length == '0) || (length > max_frame_q);
	// final frame byte when at most one byte is left (type byte counts)
	assign fin     = (remain_q <= LEN_W'(1));

	always_comb begin
		phase_d     = phase_q;
		len_acc_d   = len_acc_q;
		remain_d    = remain_q;
		res_valid_d = res_valid_q && !frame.ready;
		res_kind_d  = res_kind_q;
		res_value_d = res_value_q;
		res_last_d  = res_last_q;

		if (take) begin
			unique case (phase_q)
				PH_LEN0: begin
					len_acc_d = {len_acc_q[LEN_W-2*BYTE_W-1:0], rx.rx_byte};
					phase_d   = PH_LEN1;
				end
				PH_LEN1: begin
					len_acc_d = {len_acc_q[LEN_W-2*BYTE_W-1:0], rx.rx_byte};
					phase_d   = PH_LEN2;
				end
				PH_LEN2: begin
					len_acc_d = {len_acc_q[LEN_W-2*BYTE_W-1:0], rx.rx_byte};
					phase_d   = PH_LEN3;
				end
				PH_LEN3: begin
					len_acc_d = '0;
					if (len_bad) begin
						// zero or oversize length: one error beat, then silence
						phase_d     = PH_DEAD;
						res_valid_d = 1'b1;
						res_kind_d  = KIND_ERROR;
						res_value_d = '0;
						res_last_d  = 1'b1;
					end else begin
						remain_d = length;
						phase_d  = PH_TYPE;
					end
				end
				PH_TYPE, PH_PAYLOAD: begin
					res_valid_d = 1'b1;
					res_kind_d  = (phase_q == PH_TYPE) ? KIND_TYPE : KIND_PAYLOAD;
					res_value_d = rx.rx_byte;
					res_last_d  = fin;
					if (fin) begin
						remain_d  = '0;
						len_acc_d = '0;
						phase_d   = PH_LEN0;
					end else begin
						remain_d = remain_q - LEN_W'(1);
						phase_d  = PH_PAYLOAD;
					end
				end
				default: begin
					// dead phase (and the unused code): bytes are dropped
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN0;
			len_acc_q   <= '0;
			remain_q    <= '0;
			res_valid_q <= 1'b0;
			max_frame_q <= MAX_FRAME_RST;
		end else begin
			phase_q     <= phase_d;
			len_acc_q   <= len_acc_d;
			remain_q    <= remain_d;
			res_valid_q <= res_valid_d;
			if (cfg.valid) begin
				max_frame_q <= cfg.data;
			end
		end
	end

	// payload of the result register, no reset needed
	always_ff @(posedge clk) begin
		res_kind_q  <= res_kind_d;
		res_value_q <= res_value_d;
		res_last_q  <= res_last_d;
	end

	assign frame.valid = res_valid_q;
	assign frame.kind  = res_kind_q;
	assign frame.value = res_value_q;
	assign frame.last  = res_last_q;

endmodule

@@ rtl/ldf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_checker - port-level checks for the deframer
// Watches the byte and frame channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ldf_checker import ldf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rx_valid,
	input logic              rx_ready,
	input logic              fr_valid,
	input logic              fr_ready,
	input logic [KIND_W-1:0] fr_kind,
	input logic [BYTE_W-1:0] fr_value,
	input logic              fr_last
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !fr_ready |=> fr_valid && $stable(fr_kind) && $stable(fr_value)
			&& $stable(fr_last))
		else $error("ldf: stalled frame beat changed");

	// an error beat is last and carries zero
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && fr_kind == KIND_ERROR |-> fr_last && fr_value == '0)
		else $error("ldf: malformed error beat");

	// once the error has gone out, the block stays silent
	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && fr_ready && fr_kind == KIND_ERROR |=> !fr_valid)
		else $error("ldf: output after stream error");

	// with nothing waiting on the output, the byte side is open
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!fr_valid |-> rx_ready)
		else $error("ldf: rx stalled with empty output");

	// byte side also open when the waiting beat is being taken
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && fr_ready && rx_valid |-> rx_ready)
		else $error("ldf: rx stalled while output drains");

endmodule

bind length_prefixed_frame_deframer ldf_checker u_ldf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_valid (rx.valid),
	.rx_ready (rx.ready),
	.fr_valid (frame.valid),
	.fr_ready (frame.ready),
	.fr_kind  (frame.kind),
	.fr_value (frame.value),
	.fr_last  (frame.last)
);
